// ===== hw/rtl/fiv_pkg.sv =====
// Shared constants, codes and the byte-wide CRC-32 update for the firmware image validator.
// No dependencies; every other file of the block imports this package.
package fiv_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int HEADER_BYTES   = 32;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int LEN_W      = 24;
  localparam int VERDICT_W  = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Header layout.
  localparam int MAGIC_LEN = 6;
  localparam int SUM_FIRST = 6;
  localparam int CRC_FIRST = 10;
  localparam int VER_FIRST = 28;

  localparam logic [BYTE_W-1:0] MAGIC_WORD [MAGIC_LEN] =
    '{8'h44, 8'h49, 8'h47, 8'h49, 8'h55, 8'h4D};

  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] CRC_SEED = 32'hFFFF_FFFF;

  localparam logic [LEN_W-1:0] SIZE_LIMIT_RST = 24'd1507360;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT  = 8'd1;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPTED  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_INVALID   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_VERSION   = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_LARGE = 2'd3;

  // Reflected CRC-32 over one byte; the eight shifts collapse into an XOR matrix.
  function automatic logic [WORD_W-1:0] crc32_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/fiv_channels_if.sv =====
// Valid/ready channel interfaces of the firmware image validator: image bytes in,
// verdicts out, and the configuration write channel. Depends on fiv_pkg.
interface fiv_in_if import fiv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] image_byte;
  logic              final_byte;

  modport source (output valid, output image_byte, output final_byte, input ready);
  modport sink   (input valid, input image_byte, input final_byte, output ready);
endinterface

interface fiv_out_if import fiv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [WORD_W-1:0]    computed_crc;
  logic [WORD_W-1:0]    header_version;
  logic [LEN_W-1:0]     image_length;

  modport source (output valid, output verdict, output computed_crc,
                  output header_version, output image_length, input ready);
  modport sink   (input valid, input verdict, input computed_crc,
                  input header_version, input image_length, output ready);
endinterface

interface fiv_cfg_if import fiv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

// ===== hw/rtl/firmware_image_validator.sv =====
// Firmware image validator: one image byte per cycle, one verdict per image.
// The result is registered and appears in the cycle after the final byte's transaction.
// One byte per cycle unless stalled; the byte-wide CRC update and the header checks
// fit between the image state registers and the result register.
// in_ch.ready drops only while a result waits in the output register unclaimed.
// Reset (rst_n low, sync) clears image state, out_valid_r; presets config registers.
module firmware_image_validator import fiv_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fiv_cfg_if.sink   cfg_ch,
  fiv_in_if.sink    in_ch,
  fiv_out_if.source out_ch
);

  localparam int CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

  // Configuration registers.
  logic [WORD_W-1:0] exp_version_r;
  logic [LEN_W-1:0]  size_limit_r;

  // Per-image state.
  logic [WORD_W-1:0]     crc_r,     crc_nxt;
  logic [COUNT_BITS-1:0] count_r,   count_nxt;
  logic                  magic_r,   magic_nxt;
  logic [WORD_W-1:0]     sum_r,     sum_nxt;
  logic [WORD_W-1:0]     version_r, version_nxt;

  // Output register.
  logic                 out_valid_r;
  logic [VERDICT_W-1:0] verdict_r,  verdict_nxt;
  logic [WORD_W-1:0]    out_crc_r,  out_crc_nxt;
  logic [WORD_W-1:0]    out_ver_r;
  logic [LEN_W-1:0]     out_len_r;

  logic                  in_acc;
  logic [WORD_W-1:0]     crc_upd;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  magic_upd;
  logic [WORD_W-1:0]     sum_upd;
  logic [WORD_W-1:0]     version_upd;
  logic [1:0]            sum_lane;
  logic [1:0]            ver_lane;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r <= '0;
      size_limit_r  <= SIZE_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        CFG_EXP_VERSION: exp_version_r <= cfg_ch.wdata;
        CFG_SIZE_LIMIT:  size_limit_r  <= cfg_ch.wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign sum_lane = 2'(count_r - COUNT_BITS'(SUM_FIRST));
  assign ver_lane = 2'(count_r - COUNT_BITS'(VER_FIRST));

  // Header capture and CRC update for the byte at offset count_r.
  always_comb begin
    magic_upd   = magic_r;
    sum_upd     = sum_r;
    version_upd = version_r;
    crc_upd     = crc_r;
    if (count_r < COUNT_BITS'(MAGIC_LEN)) begin
      if (in_ch.image_byte != MAGIC_WORD[count_r[2:0]]) begin
        magic_upd = 1'b0;
      end
    end else if (count_r < COUNT_BITS'(CRC_FIRST)) begin
      sum_upd[sum_lane*BYTE_W +: BYTE_W] = in_ch.image_byte;
    end
    if (count_r >= COUNT_BITS'(VER_FIRST) && count_r < COUNT_BITS'(HEADER_BYTES)) begin
      version_upd[ver_lane*BYTE_W +: BYTE_W] = in_ch.image_byte;
    end
    if (count_r >= COUNT_BITS'(CRC_FIRST)) begin
      crc_upd = crc32_byte(crc_r, in_ch.image_byte);
    end
    count_inc = (count_r == '1) ? count_r : count_r + 1'b1;
  end

  // The verdict is formed from the updated state, with the final byte included.
  always_comb begin
    out_crc_nxt = ~crc_upd;
    if (count_inc < COUNT_BITS'(HEADER_BYTES) || !magic_upd || sum_upd != out_crc_nxt) begin
      verdict_nxt = VERDICT_INVALID;
    end else if (version_upd != exp_version_r) begin
      verdict_nxt = VERDICT_VERSION;
    end else if (CMP_W'(count_inc) > CMP_W'(size_limit_r)) begin
      verdict_nxt = VERDICT_TOO_LARGE;
    end else begin
      verdict_nxt = VERDICT_ACCEPTED;
    end
  end

  always_comb begin
    crc_nxt     = crc_r;
    count_nxt   = count_r;
    magic_nxt   = magic_r;
    sum_nxt     = sum_r;
    version_nxt = version_r;
    if (in_acc) begin
      if (in_ch.final_byte) begin
        crc_nxt     = CRC_SEED;
        count_nxt   = '0;
        magic_nxt   = 1'b1;
        sum_nxt     = '0;
        version_nxt = '0;
      end else begin
        crc_nxt     = crc_upd;
        count_nxt   = count_inc;
        magic_nxt   = magic_upd;
        sum_nxt     = sum_upd;
        version_nxt = version_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= CRC_SEED;
      count_r   <= '0;
      magic_r   <= 1'b1;
      sum_r     <= '0;
      version_r <= '0;
    end else begin
      crc_r     <= crc_nxt;
      count_r   <= count_nxt;
      magic_r   <= magic_nxt;
      sum_r     <= sum_nxt;
      version_r <= version_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_ch.final_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.final_byte) begin
      verdict_r <= verdict_nxt;
      out_crc_r <= out_crc_nxt;
      out_ver_r <= version_upd;
      out_len_r <= LEN_W'(count_inc);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.verdict        = verdict_r;
  assign out_ch.computed_crc   = out_crc_r;
  assign out_ch.header_version = out_ver_r;
  assign out_ch.image_length   = out_len_r;

  // A byte that does not end the image never produces a result.
  a_no_result_mid_image: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_ch.final_byte |=> !out_valid_r)
    else $error("result raised for a byte that was not final");

  // The final byte returns the image state to its starting values.
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.final_byte |=> count_r == '0 && magic_r && crc_r == CRC_SEED)
    else $error("image state not cleared after final byte");

  // Mid-image the byte count stays nonzero.
  a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_ch.final_byte |=> count_r != '0)
    else $error("byte count did not advance");

  // An image that ends before offset 10 reports a zero CRC and an invalid verdict.
  a_short_crc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.final_byte && count_r < COUNT_BITS'(CRC_FIRST)
    |=> out_crc_r == '0 && verdict_r == VERDICT_INVALID)
    else $error("short image gave nonzero CRC or a non-invalid verdict");

endmodule
